// ===== design/ppg_pkg.sv =====
// ----------------------------------------------------------------------------
// PPG beat interval detector package
// Shared constants, codes and types for the beat interval detector blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package ppg_pkg;

  // Default lane count and fixed sample width of the channel fields.
  localparam int unsigned CHANNELS_DEF   = 4;
  localparam int unsigned FIELD_CHANNELS = 4;
  localparam int unsigned SAMPLE_BITS    = 24;
  localparam int unsigned MARGIN_W       = 23;
  localparam int unsigned ADDR_W         = 5;

  // Input tdata layout, lowest bit first.
  localparam int unsigned IN_TIME_LSB = 0;
  localparam int unsigned IN_EN_BIT   = 32;
  localparam int unsigned IN_CH_LSB   = 33;
  localparam int unsigned IN_DATA_W   = 136;
  localparam int unsigned OUT_DATA_W  = 136;

  // Channel grades.
  localparam logic [1:0] GRADE_INVALID = 2'd0;
  localparam logic [1:0] GRADE_LOW     = 2'd1;
  localparam logic [1:0] GRADE_VALID   = 2'd2;

  // Tracking modes.
  localparam logic [2:0] MODE_INIT      = 3'd0;
  localparam logic [2:0] MODE_ACQUIRE   = 3'd1;
  localparam logic [2:0] MODE_REACQUIRE = 3'd2;
  localparam logic [2:0] MODE_HOLD      = 3'd3;
  localparam logic [2:0] MODE_TRACK     = 3'd4;

  // Reject codes.
  localparam logic [2:0] REJ_NONE      = 3'd0;
  localparam logic [2:0] REJ_DISABLED  = 3'd1;
  localparam logic [2:0] REJ_SATURATED = 3'd2;
  localparam logic [2:0] REJ_DROP      = 3'd3;
  localparam logic [2:0] REJ_GAP       = 3'd4;
  localparam logic [2:0] REJ_LOWQ      = 3'd5;
  localparam logic [2:0] REJ_RANGE     = 3'd6;

  // Bit positions in the flags field.
  localparam int unsigned FL_SELECTED  = 0;
  localparam int unsigned FL_DISABLED  = 1;
  localparam int unsigned FL_SATURATED = 2;
  localparam int unsigned FL_DROP      = 3;
  localparam int unsigned FL_GAP       = 4;
  localparam int unsigned FL_LOWQ      = 5;

  // Configuration register indexes.
  localparam logic [2:0] REG_EXPECTED = 3'd0;
  localparam logic [2:0] REG_MIN      = 3'd1;
  localparam logic [2:0] REG_MAX      = 3'd2;
  localparam logic [2:0] REG_STRICT   = 3'd3;
  localparam logic [2:0] REG_MARGIN   = 3'd4;
  localparam logic [2:0] REG_QTHR     = 3'd5;

  // Configuration register set.
  typedef struct packed {
    logic [15:0]         spacing_ms;
    logic [15:0]         ibi_min_ms;
    logic [15:0]         ibi_max_ms;
    logic                strict_time_check;
    logic [MARGIN_W-1:0] saturation_margin;
    logic [1:0]          quality_threshold;
  } cfg_t;

  // Sample held in the first stage, besides the lane values.
  typedef struct packed {
    logic        cmd;
    logic        en;
    logic        drop;
    logic        gap;
    logic [31:0] time_ms;
  } stage_t;

  // What the merge stage found over all lanes.
  typedef struct packed {
    logic [1:0] quality;
    logic       saturated;
  } merge_t;

  // One result; the first field ends up in the highest bits.
  typedef struct packed {
    logic [5:0]  flags;
    logic [2:0]  reject_code;
    logic [2:0]  mode;
    logic [2:0]  chosen_channel;
    logic [1:0]  quality;
    logic [1:0]  confidence;
    logic [31:0] beats;
    logic [15:0] ibi_ms;
    logic [31:0] event_sample_number;
    logic [31:0] event_time_ms;
    logic        event_ready;
  } result_t;

endpackage

`default_nettype wire

// ===== design/ppg_beat_interval_detector.sv =====
// ----------------------------------------------------------------------------
// PPG beat interval detector
// Grades multi-channel PPG samples, detects pulse peaks and reports beat
// intervals, one result for each processed sample.
// ----------------------------------------------------------------------------
// The block takes one sample request per clock while the output is not
// stalled and returns one result for every request whose tuser (command) is
// 0; a request with tuser 1 clears the counters, the mode and the detector
// and returns nothing. A sample goes through two registers: the lane stage,
// where every channel is graded and the timestamp spacing is checked, and
// the detector stage, which writes the output register. The detector state
// update in the second stage takes one sample per clock, which sets the
// sustained rate at one request per cycle while the result side keeps taking
// results. Configuration is read on the fly and should be written only while
// no request is in flight.
`default_nettype none

module ppg_beat_interval_detector
  import ppg_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Sample requests.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: time_ms[31:0], measure_enable[32], channel0_value[56:33],
  // channel1_value[80:57], channel2_value[104:81], channel3_value[128:105]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: command
  input  wire logic                  s_axis_tuser,
  // Results.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: event_ready[0], event_time_ms[32:1], event_sample_number[64:33],
  // ibi_ms[80:65], beats[112:81], confidence[114:113], quality[116:115],
  // chosen_channel[119:117], mode[122:120], reject_code[125:123],
  // flags[131:126]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // Configuration port.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned IdxW = $clog2(CHANNELS + 1);

  cfg_t                          cfg_q, cfg_d;
  logic                          s_accept;
  logic                          advance;
  logic                          step;
  logic                          s1_valid_q, s1_valid_d;
  stage_t                        s1_q, s1_d;
  logic [31:0]                   last_time_q, last_time_d;
  logic                          have_last_q, have_last_d;
  logic [31:0]                   time_diff;
  logic                          m_valid_q, m_valid_d;
  result_t                       res_q;
  result_t                       res;
  logic signed [SAMPLE_BITS-1:0] raw     [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] values  [CHANNELS];
  logic [1:0]                    grades  [CHANNELS];
  logic                          gts     [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] newer_value;
  merge_t                        merge;
  logic [IdxW-1:0]               chosen;
  logic                          cfg_write;

  // Handshakes: the output register parts the two sides.
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign advance       = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;
  assign step          = s1_valid_q && advance;

  // Timestamp spacing check against the previous sample.
  assign time_diff = s_axis_tdata[IN_TIME_LSB +: 32] - last_time_q;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_d        = s1_q;
    last_time_d = last_time_q;
    have_last_d = have_last_q;
    if (s_accept) begin
      s1_valid_d   = 1'b1;
      s1_d.cmd     = s_axis_tuser;
      s1_d.en      = s_axis_tdata[IN_EN_BIT];
      s1_d.time_ms = s_axis_tdata[IN_TIME_LSB +: 32];
      s1_d.drop    = have_last_q && cfg_q.strict_time_check &&
                     (time_diff > 32'(cfg_q.spacing_ms));
      s1_d.gap     = have_last_q && cfg_q.strict_time_check &&
                     (time_diff < 32'(cfg_q.spacing_ms));
      if (s_axis_tuser) begin
        last_time_d = '0;
        have_last_d = 1'b0;
      end else begin
        last_time_d = s_axis_tdata[IN_TIME_LSB +: 32];
        have_last_d = 1'b1;
      end
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
  end

  // Lane stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      have_last_q <= 1'b0;
      last_time_q <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      have_last_q <= have_last_d;
      last_time_q <= last_time_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // One lane per channel; lanes past the input fields see zero.
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    if (g < FIELD_CHANNELS) begin : g_field
      assign raw[g] = s_axis_tdata[IN_CH_LSB + g*SAMPLE_BITS +: SAMPLE_BITS];
    end else begin : g_zero
      assign raw[g] = '0;
    end

    ppg_lane u_lane (
      .clk_i    (clk_i),
      .load_i   (s_accept),
      .raw_i    (raw[g]),
      .margin_i (cfg_q.saturation_margin),
      .newer_i  (newer_value),
      .value_o  (values[g]),
      .grade_o  (grades[g]),
      .gt_o     (gts[g])
    );
  end

  ppg_merge #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IdxW)
  ) u_merge (
    .grade_i  (grades),
    .merge_o  (merge),
    .chosen_o (chosen)
  );

  ppg_beat #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IdxW)
  ) u_beat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .stage_i  (s1_q),
    .cfg_i    (cfg_q),
    .merge_i  (merge),
    .chosen_i (chosen),
    .values_i (values),
    .gt_i     (gts),
    .newer_o  (newer_value),
    .res_o    (res)
  );

  // Output register.
  assign m_valid_d = advance ? (s1_valid_q && !s1_q.cmd) : m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && !s1_q.cmd) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(res_q);

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      unique case (paddr[ADDR_W-1:2])
        REG_EXPECTED: cfg_d.spacing_ms        = pwdata[15:0];
        REG_MIN:      cfg_d.ibi_min_ms        = pwdata[15:0];
        REG_MAX:      cfg_d.ibi_max_ms        = pwdata[15:0];
        REG_STRICT:   cfg_d.strict_time_check = pwdata[0];
        REG_MARGIN:   cfg_d.saturation_margin = pwdata[MARGIN_W-1:0];
        REG_QTHR:     cfg_d.quality_threshold = pwdata[1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spacing_ms        <= 16'd40;
      cfg_q.ibi_min_ms        <= 16'd300;
      cfg_q.ibi_max_ms        <= 16'd2000;
      cfg_q.strict_time_check <= 1'b1;
      cfg_q.saturation_margin <= MARGIN_W'(65536);
      cfg_q.quality_threshold <= 2'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register read back.
  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_EXPECTED: prdata = 32'(cfg_q.spacing_ms);
      REG_MIN:      prdata = 32'(cfg_q.ibi_min_ms);
      REG_MAX:      prdata = 32'(cfg_q.ibi_max_ms);
      REG_STRICT:   prdata = 32'(cfg_q.strict_time_check);
      REG_MARGIN:   prdata = 32'(cfg_q.saturation_margin);
      REG_QTHR:     prdata = 32'(cfg_q.quality_threshold);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ppg_lane.sv =====
// ----------------------------------------------------------------------------
// PPG channel lane
// Grades one channel sample against full scale, holds it for the detector
// stage and compares it against the stored detector sample.
// ----------------------------------------------------------------------------
`default_nettype none

module ppg_lane
  import ppg_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          load_i,
  input  wire logic signed [SAMPLE_BITS-1:0] raw_i,
  input  wire logic [MARGIN_W-1:0]           margin_i,
  input  wire logic signed [SAMPLE_BITS-1:0] newer_i,
  output logic signed [SAMPLE_BITS-1:0]      value_o,
  output logic [1:0]                         grade_o,
  output logic                               gt_o
);

  localparam logic signed [SAMPLE_BITS:0] LoVal = {2'b11, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS:0] HiVal = {2'b00, {(SAMPLE_BITS-1){1'b1}}};

  logic signed [SAMPLE_BITS:0]      raw_ext;
  logic signed [SAMPLE_BITS:0]      margin_ext;
  logic [1:0]                       grade_d;
  logic signed [SAMPLE_BITS-1:0]    value_q;
  logic [1:0]                       grade_q;

  // Full scale is invalid; within the margin of full scale is low.
  always_comb begin
    raw_ext    = {raw_i[SAMPLE_BITS-1], raw_i};
    margin_ext = $signed((SAMPLE_BITS+1)'(margin_i));
    if (raw_ext <= LoVal || raw_ext >= HiVal) begin
      grade_d = GRADE_INVALID;
    end else if (raw_ext <= LoVal + margin_ext || raw_ext >= HiVal - margin_ext) begin
      grade_d = GRADE_LOW;
    end else begin
      grade_d = GRADE_VALID;
    end
  end

  // Sample and grade are held for the detector stage.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q <= raw_i;
      grade_q <= grade_d;
    end
  end

  assign value_o = value_q;
  assign grade_o = grade_q;
  assign gt_o    = value_q > newer_i;

endmodule

`default_nettype wire

// ===== design/ppg_merge.sv =====
// ----------------------------------------------------------------------------
// PPG lane merge
// Picks the first channel with the best grade and notes any saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module ppg_merge
  import ppg_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF,
  parameter int unsigned IDX_W    = $clog2(CHANNELS + 1)
) (
  input  wire logic [1:0] grade_i [CHANNELS],
  output merge_t          merge_o,
  output logic [IDX_W-1:0] chosen_o
);

  // A later lane only wins with a strictly better grade.
  always_comb begin
    merge_o.quality   = GRADE_INVALID;
    merge_o.saturated = 1'b0;
    chosen_o          = IDX_W'(CHANNELS);
    for (int i = 0; i < CHANNELS; i++) begin
      if (grade_i[i] > merge_o.quality) begin
        merge_o.quality = grade_i[i];
        chosen_o        = IDX_W'(i);
      end
      if (grade_i[i] == GRADE_INVALID) begin
        merge_o.saturated = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/ppg_beat.sv =====
// ----------------------------------------------------------------------------
// PPG beat detector stage
// Applies the reject rules, runs the mode machine and the three-point peak
// detector, range-checks the beat interval and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ppg_beat
  import ppg_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF,
  parameter int unsigned IDX_W    = $clog2(CHANNELS + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire stage_t                        stage_i,
  input  wire cfg_t                          cfg_i,
  input  wire merge_t                        merge_i,
  input  wire logic [IDX_W-1:0]              chosen_i,
  input  wire logic signed [SAMPLE_BITS-1:0] values_i [CHANNELS],
  input  wire logic                          gt_i [CHANNELS],
  output logic signed [SAMPLE_BITS-1:0]      newer_o,
  output result_t                            res_o
);

  localparam logic [IDX_W-1:0] NoChannel = IDX_W'(CHANNELS);

  logic [31:0]                   count_q, count_d;
  logic [31:0]                   beat_q, beat_d;
  logic [2:0]                    mode_q, mode_d;
  logic signed [SAMPLE_BITS-1:0] newer_value_q, newer_value_d;
  logic [31:0]                   newer_time_q, newer_time_d;
  logic [31:0]                   newer_number_q, newer_number_d;
  logic [IDX_W-1:0]              newer_channel_q, newer_channel_d;
  logic                          newer_gt_older_q, newer_gt_older_d;
  logic                          have_older_q, have_older_d;
  logic                          have_newer_q, have_newer_d;
  logic [31:0]                   pulse_time_q, pulse_time_d;
  logic                          have_pulse_q, have_pulse_d;

  logic signed [SAMPLE_BITS-1:0] cur_value;
  logic                          cur_gt;
  logic [31:0]                   count_inc;
  logic [31:0]                   ibi;
  logic                          ibi_ok;
  logic                          allowed;
  logic                          peak;
  logic [2:0]                    rej;
  logic [5:0]                    flags;
  logic [2:0]                    mode_mid;

  // Chosen lane's sample and its compare against the stored newer sample.
  always_comb begin
    cur_value = '0;
    cur_gt    = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (chosen_i == IDX_W'(i)) begin
        cur_value = values_i[i];
        cur_gt    = gt_i[i];
      end
    end
  end

  // The interval depends on stored state only.
  assign count_inc = count_q + 32'd1;
  assign ibi       = newer_time_q - pulse_time_q;
  assign ibi_ok    = (ibi >= 32'(cfg_i.ibi_min_ms)) &&
                     (ibi <= 32'(cfg_i.ibi_max_ms));

  // Reject rules in priority order: disabled, saturated, drop or gap, low quality.
  always_comb begin
    rej      = REJ_NONE;
    flags    = '0;
    mode_mid = mode_q;
    allowed  = 1'b0;
    if (!stage_i.en) begin
      mode_mid           = MODE_HOLD;
      rej                = REJ_DISABLED;
      flags[FL_DISABLED] = 1'b1;
    end else begin
      if (mode_q == MODE_HOLD) begin
        mode_mid = MODE_REACQUIRE;
      end else if (mode_q == MODE_INIT) begin
        mode_mid = MODE_ACQUIRE;
      end
      flags[FL_SELECTED] = (chosen_i != NoChannel);
      if (merge_i.saturated) begin
        rej                 = REJ_SATURATED;
        flags[FL_SATURATED] = 1'b1;
      end
      if (stage_i.drop) begin
        if (rej == REJ_NONE) begin
          rej = REJ_DROP;
        end
        flags[FL_DROP] = 1'b1;
      end else if (stage_i.gap) begin
        if (rej == REJ_NONE) begin
          rej = REJ_GAP;
        end
        flags[FL_GAP] = 1'b1;
      end
      if (rej == REJ_NONE && merge_i.quality < cfg_i.quality_threshold) begin
        rej            = REJ_LOWQ;
        flags[FL_LOWQ] = 1'b1;
      end
      allowed = (rej == REJ_NONE) && (chosen_i != NoChannel);
    end
  end

  // Local maximum: newer above older and not below the current sample.
  assign peak = allowed && have_older_q && have_newer_q &&
                (newer_channel_q == chosen_i) && newer_gt_older_q && !cur_gt;

  // Next state and the result.
  always_comb begin
    count_d          = count_q;
    beat_d           = beat_q;
    mode_d           = mode_q;
    newer_value_d    = newer_value_q;
    newer_time_d     = newer_time_q;
    newer_number_d   = newer_number_q;
    newer_channel_d  = newer_channel_q;
    newer_gt_older_d = newer_gt_older_q;
    have_older_d     = have_older_q;
    have_newer_d     = have_newer_q;
    pulse_time_d     = pulse_time_q;
    have_pulse_d     = have_pulse_q;

    res_o                     = '0;
    res_o.event_time_ms       = stage_i.time_ms;
    res_o.event_sample_number = count_inc;
    res_o.quality             = stage_i.en ? merge_i.quality : GRADE_INVALID;
    res_o.chosen_channel      = stage_i.en ? 3'(chosen_i) : 3'(NoChannel);
    res_o.flags               = flags;
    res_o.reject_code         = rej;

    if (step_i) begin
      if (stage_i.cmd) begin
        count_d      = '0;
        beat_d       = '0;
        mode_d       = MODE_INIT;
        have_older_d = 1'b0;
        have_newer_d = 1'b0;
        have_pulse_d = 1'b0;
        newer_channel_d = NoChannel;
      end else begin
        count_d = count_inc;
        mode_d  = mode_mid;
        if (allowed) begin
          if (peak) begin
            if (have_pulse_q) begin
              if (ibi_ok) begin
                beat_d                    = beat_q + 32'd1;
                mode_d                    = MODE_TRACK;
                res_o.event_ready         = 1'b1;
                res_o.event_time_ms       = newer_time_q;
                res_o.event_sample_number = newer_number_q;
                res_o.ibi_ms              = ibi[15:0];
                res_o.confidence          = merge_i.quality;
              end else begin
                res_o.reject_code = REJ_RANGE;
              end
            end
            pulse_time_d = newer_time_q;
            have_pulse_d = 1'b1;
          end
          newer_gt_older_d = cur_gt;
          have_older_d     = have_newer_q;
          newer_value_d    = cur_value;
          newer_time_d     = stage_i.time_ms;
          newer_number_d   = count_inc;
          newer_channel_d  = chosen_i;
          have_newer_d     = 1'b1;
        end else begin
          // Every refused sample here is a strict reject.
          have_older_d = 1'b0;
          have_newer_d = 1'b0;
          have_pulse_d = 1'b0;
        end
      end
    end

    res_o.beats = beat_d;
    res_o.mode  = mode_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q         <= '0;
      beat_q          <= '0;
      mode_q          <= MODE_INIT;
      have_older_q    <= 1'b0;
      have_newer_q    <= 1'b0;
      have_pulse_q    <= 1'b0;
      newer_channel_q <= NoChannel;
    end else begin
      count_q         <= count_d;
      beat_q          <= beat_d;
      mode_q          <= mode_d;
      have_older_q    <= have_older_d;
      have_newer_q    <= have_newer_d;
      have_pulse_q    <= have_pulse_d;
      newer_channel_q <= newer_channel_d;
    end
  end

  // Detector payload, qualified by the have flags.
  always_ff @(posedge clk_i) begin
    newer_value_q    <= newer_value_d;
    newer_time_q     <= newer_time_d;
    newer_number_q   <= newer_number_d;
    newer_gt_older_q <= newer_gt_older_d;
    pulse_time_q     <= pulse_time_d;
  end

  assign newer_o = newer_value_q;

endmodule

`default_nettype wire

// ===== design/ppg_checker.sv =====
// ----------------------------------------------------------------------------
// PPG beat interval detector checker
// Port-level assertions on the stream handshakes and the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module ppg_checker
  import ppg_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

  result_t res;

  assign res = m_axis_tdata[$bits(result_t)-1:0];

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Requests are only refused while a result is waiting to be taken.
  a_back_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("request refused without output back pressure");

  // An event puts the block in track mode with no reject.
  a_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.event_ready |->
      res.reject_code == REJ_NONE && res.mode == MODE_TRACK &&
      res.confidence == res.quality)
    else $error("event result with inconsistent status");

  // A disabled measurement holds and reports nothing else.
  a_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.flags[FL_DISABLED] |->
      res.mode == MODE_HOLD && res.reject_code == REJ_DISABLED &&
      res.quality == GRADE_INVALID && !res.event_ready)
    else $error("disabled result with inconsistent status");

endmodule

bind ppg_beat_interval_detector ppg_checker u_ppg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
